FILE: rtl/sfir_pkg.sv
// Shared types and constants for the stereo FIR filter.
// Used by every module of the block; depends on nothing.
package sfir_pkg;

   localparam int TAPS      = 32;
   localparam int FRAC_BITS = 15;
   localparam int SAMPLE_W  = 16;
   localparam int ACC_W     = 32;
   localparam int INDEX_W   = 5;
   localparam int CNT_W     = $clog2(TAPS);

   // Item codes carried in the req_type field
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEF   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic                       req_type;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic        [INDEX_W-1:0]  coef_index;
      logic signed [SAMPLE_W-1:0] coef_value;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_result;
      logic signed [SAMPLE_W-1:0] right_result;
      logic                       overflow;
   } rsp_word_type;

   // Contents of one cell of the tap chain
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] coef;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } cell_data_type;

   // Chain moves: push shifts history toward the tail, rotate moves all toward the head
   typedef struct packed {
      logic push;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic capture;
   } mac_ctrl_type;

endpackage

FILE: rtl/sfir_cell.sv
// One tap cell: holds a coefficient and one left and one right history sample.
// Depends on sfir_pkg for the cell data and control types.
module sfir_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  sfir_pkg::cell_ctrl_type             ctrl,
   input  logic                                coef_we,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0] coef_wdata,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0] left_prev,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0] right_prev,
   input  sfir_pkg::cell_data_type             next_cell,
   output sfir_pkg::cell_data_type             cell_out
);

   sfir_pkg::cell_data_type cell_ff;
   sfir_pkg::cell_data_type cell_in;

   // Select the next contents: coefficient load, history push or chain rotate
   always_comb begin
      cell_in = cell_ff;
      if (coef_we) begin
         cell_in.coef = coef_wdata;
      end else if (ctrl.push) begin
         cell_in.left  = left_prev;
         cell_in.right = right_prev;
      end else if (ctrl.rotate) begin
         cell_in = next_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

FILE: rtl/sfir_mac.sv
// Two-lane multiply-accumulate at the head of the tap chain, with output scaling.
// Depends on sfir_pkg for widths and the control type.
module sfir_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  sfir_pkg::mac_ctrl_type              ctrl,
   input  sfir_pkg::cell_data_type             head,
   output logic signed [sfir_pkg::SAMPLE_W-1:0] left_sum,
   output logic signed [sfir_pkg::SAMPLE_W-1:0] right_sum,
   output logic                                overflow
);

   logic signed [sfir_pkg::ACC_W-1:0] prod_l_ff, prod_r_ff;
   logic signed [sfir_pkg::ACC_W-1:0] acc_l_ff, acc_r_ff;
   logic signed [sfir_pkg::ACC_W-1:0] acc_l_in, acc_r_in;
   logic                              prod_valid_ff;
   logic signed [sfir_pkg::ACC_W-1:0] shift_l, shift_r;
   logic                              fit_l, fit_r;

   // Register the products of the head cell
   always_ff @(posedge clock) begin
      prod_l_ff <= sfir_pkg::ACC_W'(head.left * head.coef);
      prod_r_ff <= sfir_pkg::ACC_W'(head.right * head.coef);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.capture;
      end
   end

   // Accumulate with 32-bit wrap; clear at the start of each sample word
   always_comb begin
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      if (ctrl.clear) begin
         acc_l_in = '0;
         acc_r_in = '0;
      end else if (prod_valid_ff) begin
         acc_l_in = acc_l_ff + prod_l_ff;
         acc_r_in = acc_r_ff + prod_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else begin
         acc_l_ff <= acc_l_in;
         acc_r_ff <= acc_r_in;
      end
   end

   // Scale down and flag values that do not fit the result width
   assign shift_l = acc_l_ff >>> sfir_pkg::FRAC_BITS;
   assign shift_r = acc_r_ff >>> sfir_pkg::FRAC_BITS;
   assign fit_l = (&shift_l[sfir_pkg::ACC_W-1:sfir_pkg::SAMPLE_W-1]) ||
                  !(|shift_l[sfir_pkg::ACC_W-1:sfir_pkg::SAMPLE_W-1]);
   assign fit_r = (&shift_r[sfir_pkg::ACC_W-1:sfir_pkg::SAMPLE_W-1]) ||
                  !(|shift_r[sfir_pkg::ACC_W-1:sfir_pkg::SAMPLE_W-1]);

   assign left_sum  = shift_l[sfir_pkg::SAMPLE_W-1:0];
   assign right_sum = shift_r[sfir_pkg::SAMPLE_W-1:0];
   assign overflow  = !(fit_l && fit_r);

endmodule

FILE: rtl/stereo_fir_filter.sv
// Stereo FIR filter top level: tap cell chain, MAC, sequencer and output register.
// A sample word passes through RUN, DRAIN and HOLD to rsp_valid when filtering, through HOLD alone when bypassed.
// No new sample word is taken until the last one has left HOLD, in either mode;
// the chain rotates once per tap through the single MAC at its head. Coefficient words are
// taken only while idle and give no result. A stalled result holds off the next sample word.
// Reset (synchronous): histories and coefficients clear to zero, filter enabled.
module stereo_fir_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sfir_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sfir_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);

   sfir_pkg::state_type     state_ff, state_in;
   logic [sfir_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                    enable_ff;
   logic                    pass_ff, pass_in;
   sfir_pkg::rsp_word_type  pass_word_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   sfir_pkg::rsp_word_type  rsp_data_ff;

   logic                    accept, accept_sample, accept_coef;
   logic                    rsp_load;
   sfir_pkg::cell_ctrl_type cell_ctrl;
   sfir_pkg::mac_ctrl_type  mac_ctrl;
   logic [sfir_pkg::TAPS-1:0] coef_we;
   sfir_pkg::cell_data_type cells [sfir_pkg::TAPS];
   logic signed [sfir_pkg::SAMPLE_W-1:0] mac_left, mac_right;
   logic                    mac_ovf;

   assign accept        = req_valid && !req_stall;
   assign accept_sample = accept && (req_data.req_type == sfir_pkg::REQ_SAMPLE);
   assign accept_coef   = accept && (req_data.req_type == sfir_pkg::REQ_COEF);
   assign rsp_load      = (state_ff == sfir_pkg::ST_HOLD) && (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfir_pkg::ST_IDLE: begin
            if (accept_sample) begin
               state_in = enable_ff ? sfir_pkg::ST_RUN : sfir_pkg::ST_HOLD;
            end
         end
         sfir_pkg::ST_RUN: begin
            if (cnt_ff == sfir_pkg::CNT_W'(sfir_pkg::TAPS - 1)) begin
               state_in = sfir_pkg::ST_DRAIN;
            end
         end
         sfir_pkg::ST_DRAIN: state_in = sfir_pkg::ST_HOLD;
         sfir_pkg::ST_HOLD: begin
            if (rsp_load) begin
               state_in = sfir_pkg::ST_IDLE;
            end
         end
         default: state_in = sfir_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall        = (state_ff != sfir_pkg::ST_IDLE);
      cell_ctrl.push   = accept_sample && enable_ff;
      cell_ctrl.rotate = (state_ff == sfir_pkg::ST_RUN);
      mac_ctrl.clear   = accept_sample && enable_ff;
      mac_ctrl.capture = (state_ff == sfir_pkg::ST_RUN);
      cnt_in           = (state_ff == sfir_pkg::ST_RUN) ? cnt_ff + 1'b1 : '0;
      pass_in          = accept_sample ? !enable_ff : pass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfir_pkg::ST_IDLE;
         cnt_ff   <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pass_ff  <= pass_in;
      end
   end

   // Hold the bypass word until the output register is free
   always_ff @(posedge clock) begin
      if (accept_sample) begin
         pass_word_ff.left_result  <= req_data.left_sample;
         pass_word_ff.right_result <= req_data.right_sample;
         pass_word_ff.overflow     <= 1'b0;
      end
   end

   // Enable register; the user must write it only while idle, which the block itself does not enforce
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         enable_ff <= csr_data;
      end
   end

   // Tap chain: push enters at cell 0, rotate feeds the tail back from the head
   for (genvar g = 0; g < sfir_pkg::TAPS; g++) begin : g_cell
      logic signed [sfir_pkg::SAMPLE_W-1:0] left_prev, right_prev;
      if (g == 0) begin : g_head
         assign left_prev  = req_data.left_sample;
         assign right_prev = req_data.right_sample;
      end else begin : g_body
         assign left_prev  = cells[g-1].left;
         assign right_prev = cells[g-1].right;
      end
      assign coef_we[g] = accept_coef && (int'(req_data.coef_index) == g);
      sfir_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .coef_we    (coef_we[g]),
         .coef_wdata (req_data.coef_value),
         .left_prev  (left_prev),
         .right_prev (right_prev),
         .next_cell  (cells[(g + 1) % sfir_pkg::TAPS]),
         .cell_out   (cells[g])
      );
   end

   sfir_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .head      (cells[0]),
      .left_sum  (mac_left),
      .right_sum (mac_right),
      .overflow  (mac_ovf)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (pass_ff) begin
            rsp_data_ff <= pass_word_ff;
         end else begin
            rsp_data_ff.left_result  <= mac_left;
            rsp_data_ff.right_result <= mac_right;
            rsp_data_ff.overflow     <= mac_ovf;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/sfir_checker.sv
// Port-level checks for the stereo FIR filter, bound to the top level.
// Depends on sfir_pkg and stereo_fir_filter.
module sfir_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input sfir_pkg::req_word_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sfir_pkg::rsp_word_type rsp_data
);

   // Stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // Sample word makes the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.req_type == sfir_pkg::REQ_SAMPLE) |=> req_stall)
      else $error("sample word accepted without going busy");

   // New result appears only out of a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared while idle");

   // Reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stereo_fir_filter sfir_checker u_sfir_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
